### hdl/i2rt_pkg.sv
package i2rt_pkg;

   localparam int unsigned DIGIT_BITS = 6;

   localparam logic [DIGIT_BITS-1:0] RADIX_MIN   = 6'd2;
   localparam logic [DIGIT_BITS-1:0] RADIX_MAX   = 6'd36;
   localparam logic [DIGIT_BITS-1:0] RADIX_RESET = 6'd10;
   localparam logic [DIGIT_BITS-1:0] RADIX_TEN   = 6'd10;
   localparam logic [DIGIT_BITS-1:0] DIGIT_NINE  = 6'd9;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   // Result of one finished long division, handed from the divider to the top level.
   typedef struct packed {
      logic                  done;
      logic [DIGIT_BITS-1:0] digit;
      logic                  last_digit;
   } div_result_type;

   function automatic logic [7:0] digit_char(input logic [DIGIT_BITS-1:0] d);
      logic [7:0] c;
      if (d > DIGIT_NINE) begin
         c = CHAR_A + {2'b00, d} - 8'd10;
      end else begin
         c = CHAR_ZERO + {2'b00, d};
      end
      return c;
   endfunction

endpackage

### hdl/i2rt_divider.sv
module i2rt_divider #(
   parameter int unsigned WORD_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [WORD_BITS-1:0]                magnitude,
   input  logic [i2rt_pkg::DIGIT_BITS-1:0]     radix,
   output i2rt_pkg::div_result_type            result
);

   localparam int unsigned CNT_BITS = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
   localparam int unsigned DB       = i2rt_pkg::DIGIT_BITS;

   logic [WORD_BITS-1:0] quo_ff;
   logic [DB-1:0]        rem_ff;
   logic [CNT_BITS-1:0]  cnt_ff;
   logic                 busy_ff;

   logic [DB:0]          trial;
   logic                 ge;
   logic [DB-1:0]        rem_next;
   logic [WORD_BITS-1:0] quo_next;
   logic                 step_end;

   // One quotient bit per cycle: the remainder stays below the radix, so a
   // single compare and subtract settles each bit.
   always_comb begin
      trial    = {rem_ff, quo_ff[WORD_BITS-1]};
      ge       = trial >= {1'b0, radix};
      rem_next = ge ? DB'(trial - {1'b0, radix}) : trial[DB-1:0];
      quo_next = {quo_ff[WORD_BITS-2:0], ge};
      step_end = busy_ff && (cnt_ff == CNT_BITS'(WORD_BITS - 1));
      result.done       = step_end;
      result.digit      = rem_next;
      result.last_digit = (quo_next == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         if (step_end) begin
            busy_ff <= (quo_next != '0);
            cnt_ff  <= '0;
         end else begin
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= magnitude;
         rem_ff <= '0;
      end else if (busy_ff) begin
         quo_ff <= quo_next;
         rem_ff <= step_end ? '0 : rem_next;
      end
   end

endmodule

### hdl/integer_to_radix_text.sv
// Each digit comes from a bit-serial long division by the radix; once all n
// digits are found, the characters go out one per cycle while the output is
// not stalled (n, plus one for a minus sign).
// A new word is taken once the last character has entered the output register.
// Reset is synchronous and active high: it sets the radix to ten and clears control.
module integer_to_radix_text #(
   parameter int unsigned WORD_BITS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [WORD_BITS-1:0]            req_value,
   input  logic                            req_signed_mode,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [7:0]                      rsp_text_char,
   output logic                            rsp_is_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [i2rt_pkg::DIGIT_BITS-1:0] csr_radix
);

   localparam int unsigned DB       = i2rt_pkg::DIGIT_BITS;
   localparam int unsigned CNT_BITS = $clog2(WORD_BITS + 1);

   i2rt_pkg::state_type       state_ff, state_in;
   i2rt_pkg::div_result_type  div_res;

   logic [DB-1:0]        radix_ff;
   logic                 sign_ff, sign_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [DB-1:0]        stack_ff [WORD_BITS];
   logic                 push, pop;
   logic                 div_start;
   logic                 negative;
   logic [WORD_BITS-1:0] magnitude;
   logic                 load_out;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_char_ff, rsp_char_in;
   logic                 rsp_last_ff, rsp_last_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= i2rt_pkg::RADIX_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_radix < i2rt_pkg::RADIX_MIN) begin
            radix_ff <= i2rt_pkg::RADIX_MIN;
         end else if (csr_radix > i2rt_pkg::RADIX_MAX) begin
            radix_ff <= i2rt_pkg::RADIX_MAX;
         end else begin
            radix_ff <= csr_radix;
         end
      end
   end

   assign negative  = req_signed_mode && req_value[WORD_BITS-1];
   assign magnitude = negative ? (~req_value + 1'b1) : req_value;

   i2rt_divider #(
      .WORD_BITS (WORD_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .magnitude (magnitude),
      .radix     (radix_ff),
      .result    (div_res)
   );

   always_comb begin
      state_in     = state_ff;
      req_stall    = (state_ff != i2rt_pkg::ST_IDLE);
      div_start    = 1'b0;
      sign_in      = sign_ff;
      count_in     = count_ff;
      push         = 1'b0;
      pop          = 1'b0;
      load_out     = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         i2rt_pkg::ST_IDLE: begin
            if (req_valid) begin
               div_start = 1'b1;
               sign_in   = negative && (radix_ff == i2rt_pkg::RADIX_TEN);
               count_in  = '0;
               state_in  = i2rt_pkg::ST_DIVIDE;
            end
         end
         i2rt_pkg::ST_DIVIDE: begin
            if (div_res.done) begin
               push     = 1'b1;
               count_in = CNT_BITS'(count_ff + 1'b1);
               if (div_res.last_digit) begin
                  state_in = i2rt_pkg::ST_EMIT;
               end
            end
         end
         i2rt_pkg::ST_EMIT: begin
            if (load_out) begin
               rsp_valid_in = 1'b1;
               if (sign_ff) begin
                  rsp_char_in = i2rt_pkg::CHAR_MINUS;
                  rsp_last_in = 1'b0;
                  sign_in     = 1'b0;
               end else begin
                  // The most significant digit was pushed last and sits on top.
                  rsp_char_in = i2rt_pkg::digit_char(stack_ff[0]);
                  rsp_last_in = (count_ff == CNT_BITS'(1));
                  pop         = 1'b1;
                  count_in    = CNT_BITS'(count_ff - 1'b1);
                  if (count_ff == CNT_BITS'(1)) begin
                     state_in = i2rt_pkg::ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = i2rt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= i2rt_pkg::ST_IDLE;
         sign_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sign_ff      <= sign_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Digit stack: a push shifts every entry down one place, a pop shifts them back up.
   always_ff @(posedge clock) begin
      if (push) begin
         stack_ff[0] <= div_res.digit;
         for (int i = 1; i < WORD_BITS; i++) begin
            stack_ff[i] <= stack_ff[i-1];
         end
      end else if (pop) begin
         for (int i = 0; i < WORD_BITS - 1; i++) begin
            stack_ff[i] <= stack_ff[i+1];
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_text_char = rsp_char_ff;
   assign rsp_is_last   = rsp_last_ff;

endmodule

### test/integer_to_radix_text_tb.sv
`timescale 1ns / 1ps

module integer_to_radix_text_tb;

   localparam int HOLD_CYCLES = 1500;

   typedef logic [i2rt_pkg::DIGIT_BITS-1:0] radix_type;

   typedef struct packed {
      logic [31:0] value;
      logic        signed_mode;
   } number_word_type;

   typedef struct packed {
      logic [7:0] text_char;
      logic       is_last;
   } text_char_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [31:0]           req_value;
   logic                  req_signed_mode;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [7:0]            rsp_text_char;
   logic                  rsp_is_last;
   logic                  csr_valid;
   logic                  csr_ready;
   radix_type             csr_radix;

   number_word_type       words_to_send[$];
   text_char_type         chars_due[$];
   int                    words_unaccepted;
   int                    mismatch_count;
   int                    send_idle_pct;
   int                    rsp_stall_pct;
   radix_type             radix_now;
   logic                  hold_request;
   logic                  hold_active;

   integer_to_radix_text #(
      .WORD_BITS(32)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .req_signed_mode(req_signed_mode),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_text_char  (rsp_text_char),
      .rsp_is_last    (rsp_is_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_radix      (csr_radix)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $realtime, what);
      mismatch_count++;
   endtask

   function automatic radix_type clamp_radix(input radix_type r);
      if (r < i2rt_pkg::RADIX_MIN) begin
         return i2rt_pkg::RADIX_MIN;
      end else if (r > i2rt_pkg::RADIX_MAX) begin
         return i2rt_pkg::RADIX_MAX;
      end
      return r;
   endfunction

   // Works out the characters of one accepted word and queues them in order.
   task automatic spell_word(input logic [31:0] value, input logic signed_mode);
      logic [31:0] magnitude;
      logic [31:0] base;
      logic [31:0] digit;
      logic [7:0]  digit_text [0:31];
      int          count;
      magnitude = value;
      base      = {26'd0, radix_now};
      count     = 0;
      if (signed_mode && value[31]) begin
         if (radix_now == i2rt_pkg::RADIX_TEN) begin
            chars_due.push_back({i2rt_pkg::CHAR_MINUS, 1'b0});
         end
         magnitude = -value;
      end
      // The loop runs at least once, so a zero magnitude spells a single '0'.
      do begin
         digit = magnitude % base;
         if (digit > i2rt_pkg::DIGIT_NINE) begin
            digit_text[count] = i2rt_pkg::CHAR_A + digit[7:0] - 8'd10;
         end else begin
            digit_text[count] = i2rt_pkg::CHAR_ZERO + digit[7:0];
         end
         count++;
         magnitude = magnitude / base;
      end while (magnitude != 0);
      for (int k = count - 1; k >= 0; k--) begin
         chars_due.push_back({digit_text[k], k == 0});
      end
   endtask

   task automatic send_word(input number_word_type w);
      req_valid       <= 1'b1;
      req_value       <= w.value;
      req_signed_mode <= w.signed_mode;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      spell_word(w.value, w.signed_mode);
      words_unaccepted--;
   endtask

   // Sender: valid is only lowered when no word follows straight away.
   initial begin
      forever begin
         @(posedge clock);
         while (words_to_send.size() != 0) begin
            send_word(words_to_send.pop_front());
            if (words_to_send.size() == 0 || $urandom_range(99) < send_idle_pct) begin
               req_valid       <= 1'b0;
               req_value       <= $urandom;
               req_signed_mode <= 1'($urandom_range(1));
               do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
            end
         end
      end
   end

   initial begin
      hold_active = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_active <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (hold_active) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      text_char_type due;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (chars_due.size() == 0) begin
            report_mismatch($sformatf("character %h with nothing outstanding", rsp_text_char));
         end else begin
            due = chars_due.pop_front();
            if (rsp_text_char !== due.text_char) begin
               report_mismatch($sformatf("text_char %h, want %h",
                                         rsp_text_char, due.text_char));
            end
            if (rsp_is_last !== due.is_last) begin
               report_mismatch($sformatf("is_last %b, want %b on char %h",
                                         rsp_is_last, due.is_last, due.text_char));
            end
         end
      end
   end

   task automatic queue_word(input logic [31:0] value, input logic signed_mode);
      words_unaccepted++;
      words_to_send.push_back({value, signed_mode});
   endtask

   task automatic wait_drained();
      while (words_unaccepted != 0 || chars_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_radix(input radix_type r);
      wait_drained();
      repeat (2) @(posedge clock);
      csr_valid <= 1'b1;
      csr_radix <= r;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      csr_radix <= radix_type'($urandom);
      radix_now = clamp_radix(r);
   endtask

   function automatic logic [31:0] random_word();
      case ($urandom_range(5))
         0:       return $urandom_range(40);
         1:       return 32'h8000_0000 + $urandom_range(20);
         2:       return 32'hFFFF_FFFF - $urandom_range(20);
         3:       return 32'd0;
         4:       return $urandom >> $urandom_range(31);
         default: return $urandom;
      endcase
   endfunction

   // Decimal corners at the reset radix, including the most negative word.
   task automatic test_radix_ten_extremes();
      queue_word(32'd0, 1'b0);
      queue_word(32'd0, 1'b1);
      queue_word(32'd9, 1'b0);
      queue_word(32'd10, 1'b0);
      queue_word(32'hFFFF_FFFF, 1'b0);
      queue_word(32'hFFFF_FFFF, 1'b1);
      queue_word(32'h8000_0000, 1'b1);
      queue_word(32'h8000_0000, 1'b0);
      queue_word(32'h7FFF_FFFF, 1'b1);
      wait_drained();
   endtask

   // Out of range radix writes clamp; negative words outside base ten carry no sign.
   task automatic test_radix_saturation();
      write_radix(6'd0);
      queue_word(32'hFFFF_FFFF, 1'b0);
      queue_word(32'h8000_0000, 1'b1);
      queue_word(32'h5555_5555, 1'b0);
      write_radix(6'd1);
      queue_word(32'd5, 1'b0);
      write_radix(6'd63);
      queue_word(32'd35, 1'b0);
      queue_word(32'd36, 1'b0);
      queue_word(32'hFFFF_FFFF, 1'b0);
      queue_word(32'hFFFF_FFFF, 1'b1);
      write_radix(6'd37);
      queue_word(32'hFFFF_FFF6, 1'b1);
      write_radix(i2rt_pkg::RADIX_MIN);
      queue_word(32'h0000_0001, 1'b0);
      write_radix(6'd16);
      queue_word(32'hDEAD_BEEF, 1'b0);
      queue_word(32'h7FFF_FFFF, 1'b1);
      write_radix(6'd11);
      queue_word(32'h8000_0001, 1'b1);
      write_radix(6'd9);
      queue_word(32'hFFFF_FFFF, 1'b1);
      wait_drained();
   endtask

   task automatic test_random_words(input int sender_pct, input int receiver_pct,
                                    input int count);
      send_idle_pct = sender_pct;
      rsp_stall_pct = receiver_pct;
      for (int i = 0; i < count; i++) begin
         if (i % 11 == 0) begin
            if (i == 0) begin
               write_radix(i2rt_pkg::RADIX_TEN);
            end else if ($urandom_range(3) == 0) begin
               write_radix(radix_type'($urandom_range(63)));
            end else begin
               write_radix(radix_type'($urandom_range(i2rt_pkg::RADIX_MIN,
                                                      i2rt_pkg::RADIX_MAX)));
            end
         end
         queue_word(random_word(), 1'($urandom_range(1)));
      end
      wait_drained();
   endtask

   // The receiver holds off long enough that the output fills and the input stalls.
   task automatic test_output_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      write_radix(6'd16);
      hold_request <= 1'b1;
      @(posedge clock);
      hold_request <= 1'b0;
      for (int i = 0; i < 6; i++) begin
         queue_word($urandom, 1'($urandom_range(1)));
      end
      wait_drained();
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_value        = '0;
      req_signed_mode  = 1'b0;
      rsp_stall        = 1'b0;
      csr_valid        = 1'b0;
      csr_radix        = '0;
      hold_request     = 1'b0;
      words_unaccepted = 0;
      mismatch_count   = 0;
      send_idle_pct    = 20;
      rsp_stall_pct    = 63;
      radix_now        = i2rt_pkg::RADIX_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_radix_ten_extremes();
      test_radix_saturation();
      test_random_words(20, 63, 34);
      test_random_words(63, 20, 34);
      test_random_words(0, 0, 34);
      test_output_backpressure();

      wait_drained();
      // Room for any stray character.
      repeat (1100) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("integer_to_radix_text_tb: clean");
      end else begin
         $display("integer_to_radix_text_tb: errors");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("integer_to_radix_text_tb: errors");
      $finish;
   end

endmodule
